// File: hw/rtl/ptt_pkg.sv
// Shared types and constants for the periodic timer table.
package ptt_pkg;

   localparam int ID_W     = 16;
   localparam int MS_W     = 26;
   localparam int STEP_W   = 16;
   localparam int SECS_W   = 16;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 3;

   // most fired ids reported per tick, lowest first
   localparam int MAX_RESULTS = 16;

   typedef logic [ID_W-1:0]     id_type;
   typedef logic [MS_W-1:0]     ms_type;
   typedef logic [STEP_W-1:0]   step_type;
   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [CMD_W-1:0]    cmd_type;

   localparam ms_type   MS_PER_SECOND   = ms_type'(1000);
   localparam step_type TICK_STEP_RESET = step_type'(200);

   localparam op_type OP_INSERT_ONCE   = op_type'(0);
   localparam op_type OP_INSERT_REPEAT = op_type'(1);
   localparam op_type OP_DELETE        = op_type'(2);
   localparam op_type OP_RELOAD        = op_type'(3);
   localparam op_type OP_TICK          = op_type'(4);

   localparam status_type ST_OK      = status_type'(0);
   localparam status_type ST_EXISTS  = status_type'(1);
   localparam status_type ST_FULL    = status_type'(2);
   localparam status_type ST_MISSING = status_type'(3);

   localparam cmd_type CMD_IDLE   = cmd_type'(0);
   localparam cmd_type CMD_INSERT = cmd_type'(1);
   localparam cmd_type CMD_DELETE = cmd_type'(2);
   localparam cmd_type CMD_RELOAD = cmd_type'(3);
   localparam cmd_type CMD_TICK   = cmd_type'(4);

   typedef struct packed {
      logic   vld;
      id_type key;
   } fire_type;

   // travels one cell per cycle along the timer chain
   typedef struct packed {
      logic     tok;
      logic     hit;
      logic     free;
      fire_type fire;
   } link_type;

   // broadcast to every timer cell
   typedef struct packed {
      cmd_type  code;
      id_type   id;
      logic     repeat_en;
      ms_type   ms;
      step_type step;
   } ctl_type;

endpackage

// File: hw/rtl/ptt_timer_cell.sv
// One timer entry of the chain: lookup link, commit and tick update.
module ptt_timer_cell (
   input  logic              clock,
   input  logic              reset,
   input  ptt_pkg::ctl_type  ctl,
   input  ptt_pkg::link_type link_in,
   output ptt_pkg::link_type link_out
);

   logic               valid_ff, valid_in;
   ptt_pkg::id_type    key_ff, key_in;
   logic               repeat_ff, repeat_in;
   ptt_pkg::ms_type    period_ff, period_in;
   ptt_pkg::ms_type    remain_ff, remain_in;
   logic               sel_hit_ff, sel_hit_in;
   logic               sel_free_ff, sel_free_in;
   ptt_pkg::link_type  link_ff, link_in_nx;
   logic               match;
   ptt_pkg::ms_type    step_ms;

   assign match    = valid_ff && (key_ff == ctl.id);
   assign step_ms  = ptt_pkg::ms_type'(ctl.step);
   assign link_out = link_ff;

   always_comb begin
      valid_in    = valid_ff;
      key_in      = key_ff;
      repeat_in   = repeat_ff;
      period_in   = period_ff;
      remain_in   = remain_ff;
      sel_hit_in  = sel_hit_ff;
      sel_free_in = sel_free_ff;

      link_in_nx.tok  = link_in.tok;
      link_in_nx.hit  = link_in.hit | (link_in.tok & match);
      link_in_nx.free = link_in.free | (link_in.tok & ~valid_ff);
      link_in_nx.fire = link_in.fire;

      if (link_in.tok) begin
         sel_hit_in  = match;
         sel_free_in = ~valid_ff & ~link_in.free;
      end

      unique case (ctl.code)
         ptt_pkg::CMD_INSERT: begin
            if (sel_free_ff) begin
               valid_in  = 1'b1;
               key_in    = ctl.id;
               repeat_in = ctl.repeat_en;
               period_in = ctl.ms;
               remain_in = ctl.ms;
            end
         end
         ptt_pkg::CMD_DELETE: begin
            if (sel_hit_ff) begin
               valid_in = 1'b0;
            end
         end
         ptt_pkg::CMD_RELOAD: begin
            if (sel_hit_ff) begin
               period_in = ctl.ms;
               remain_in = ctl.ms;
            end
         end
         ptt_pkg::CMD_TICK: begin
            link_in_nx.fire = '0;
            if (valid_ff) begin
               if (remain_ff == '0) begin
                  link_in_nx.fire.vld = 1'b1;
                  link_in_nx.fire.key = key_ff;
                  if (repeat_ff) begin
                     remain_in = period_ff;
                  end else begin
                     valid_in = 1'b0;
                  end
               end else if (remain_ff > step_ms) begin
                  remain_in = remain_ff - step_ms;
               end else begin
                  remain_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         sel_hit_ff  <= 1'b0;
         sel_free_ff <= 1'b0;
         link_ff     <= '0;
      end else begin
         valid_ff    <= valid_in;
         sel_hit_ff  <= sel_hit_in;
         sel_free_ff <= sel_free_in;
         link_ff     <= link_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      repeat_ff <= repeat_in;
      period_ff <= period_in;
      remain_ff <= remain_in;
   end

endmodule

// File: hw/rtl/ptt_sort_cell.sv
// One stage of the insertion-sort chain for fired ids.
module ptt_sort_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  ptt_pkg::fire_type fire_in,
   input  ptt_pkg::fire_type right,
   output ptt_pkg::fire_type held,
   output ptt_pkg::fire_type pass
);

   ptt_pkg::fire_type held_ff, held_in;
   ptt_pkg::fire_type pass_ff, pass_in;

   assign held = held_ff;
   assign pass = pass_ff;

   // keeps the smaller id, hands the larger one on; on shift, takes the id held to its right
   always_comb begin
      held_in = held_ff;
      pass_in = '0;
      if (shift) begin
         held_in = right;
      end else if (fire_in.vld) begin
         if (!held_ff.vld) begin
            held_in = fire_in;
         end else if (fire_in.key < held_ff.key) begin
            held_in = fire_in;
            pass_in = held_ff;
         end else begin
            pass_in = fire_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pass_ff <= '0;
      end else begin
         held_ff <= held_in;
         pass_ff <= pass_in;
      end
   end

endmodule

// File: hw/rtl/periodic_timer_table.sv
// Timer table top level: control sequencer, timer cell chain, fired-id sorter, CSR.
//
//  channel  direction  words per item
//  req_     in         one command word
//  rsp_     out        one word; a tick gives one per fired id (up to 16) or one empty
//  csr_     in/out     APB register access, tick_step_ms at offset 0
//
// Insert, delete and reload walk the timer chain one cell per cycle.
// A tick updates every cell, drains the chain through the sorter, then sends the results in order.
// One command is in progress at a time; the next is taken once the last word is loaded.
// Results wait in the output register while rsp_ready is low.
// Synchronous reset empties the table and sets tick_step_ms to 200.
module periodic_timer_table #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [15:0] req_timer_id,
   input  logic [15:0] req_timeout_seconds,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_fired_valid,
   output logic [15:0] rsp_fired_id,
   output logic        rsp_last,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DRAIN_CYCLES = ENTRIES + ptt_pkg::MAX_RESULTS + 1;
   localparam int CNT_W        = $clog2(DRAIN_CYCLES + 1);
   localparam int NSORT        = ptt_pkg::MAX_RESULTS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WALK  = 3'd1;
   localparam logic [2:0] S_RESP  = 3'd2;
   localparam logic [2:0] S_TICK  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]            state_ff, state_in;
   ptt_pkg::op_type       op_ff, op_in;
   ptt_pkg::id_type       id_ff, id_in;
   ptt_pkg::ms_type       ms_ff, ms_in;
   logic                  hit_ff, hit_in;
   logic                  free_ff, free_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   ptt_pkg::link_type     head_ff, head_in;
   ptt_pkg::step_type     step_ff, step_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   ptt_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic                  rsp_fired_valid_ff, rsp_fired_valid_in;
   ptt_pkg::id_type       rsp_fired_id_ff, rsp_fired_id_in;
   logic                  rsp_last_ff, rsp_last_in;

   ptt_pkg::ctl_type      ctl;
   ptt_pkg::cmd_type      cmd;
   ptt_pkg::link_type     link_w [ENTRIES];
   ptt_pkg::link_type     chain_end;
   ptt_pkg::fire_type     held_w [NSORT];
   ptt_pkg::fire_type     pass_w [NSORT];
   logic                  shift;
   logic                  rsp_free;
   logic                  csr_write;

   // timer cell chain
   for (genvar k = 0; k < ENTRIES; k++) begin : g_timer
      if (k == 0) begin : g_first
         ptt_timer_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .link_in  (head_ff),
            .link_out (link_w[k])
         );
      end else begin : g_rest
         ptt_timer_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .link_in  (link_w[k-1]),
            .link_out (link_w[k])
         );
      end
   end

   assign chain_end = link_w[ENTRIES-1];

   // fired-id sorter; ids beyond the last stage are dropped
   for (genvar k = 0; k < NSORT; k++) begin : g_sort
      ptt_pkg::fire_type sort_in;
      ptt_pkg::fire_type sort_right;
      if (k == 0) begin : g_first
         assign sort_in = chain_end.fire;
      end else begin : g_rest
         assign sort_in = pass_w[k-1];
      end
      if (k == NSORT - 1) begin : g_tail
         assign sort_right = '0;
      end else begin : g_body
         assign sort_right = held_w[k+1];
      end
      ptt_sort_cell u_sort (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .fire_in (sort_in),
         .right   (sort_right),
         .held    (held_w[k]),
         .pass    (pass_w[k])
      );
   end

   // CSR
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? 32'(step_ff) : 32'd0;

   always_comb begin
      step_in = step_ff;
      if (csr_write && (csr_paddr[2] == 1'b0)) begin
         step_in = csr_pwdata[15:0];
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fired_valid = rsp_fired_valid_ff;
   assign rsp_fired_id    = rsp_fired_id_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_free        = !rsp_valid_ff || rsp_ready;

   assign ctl.code      = cmd;
   assign ctl.id        = id_ff;
   assign ctl.repeat_en = (op_ff == ptt_pkg::OP_INSERT_REPEAT);
   assign ctl.ms        = ms_ff;
   assign ctl.step      = step_ff;

   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      id_in              = id_ff;
      ms_in              = ms_ff;
      hit_in             = hit_ff;
      free_in            = free_ff;
      cnt_in             = cnt_ff;
      head_in            = '0;
      cmd                = ptt_pkg::CMD_IDLE;
      shift              = 1'b0;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_status_in      = rsp_status_ff;
      rsp_fired_valid_in = rsp_fired_valid_ff;
      rsp_fired_id_in    = rsp_fired_id_ff;
      rsp_last_in        = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               id_in = req_timer_id;
               ms_in = ptt_pkg::ms_type'(req_timeout_seconds) * ptt_pkg::MS_PER_SECOND;
               if (req_opcode == ptt_pkg::OP_INSERT_ONCE ||
                   req_opcode == ptt_pkg::OP_INSERT_REPEAT ||
                   req_opcode == ptt_pkg::OP_DELETE ||
                   req_opcode == ptt_pkg::OP_RELOAD) begin
                  head_in.tok = 1'b1;
                  state_in    = S_WALK;
               end else if (req_opcode == ptt_pkg::OP_TICK) begin
                  state_in = S_TICK;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_WALK: begin
            if (chain_end.tok) begin
               hit_in   = chain_end.hit;
               free_in  = chain_end.free;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = ptt_pkg::ST_OK;
               rsp_fired_valid_in = 1'b0;
               rsp_fired_id_in    = '0;
               rsp_last_in        = 1'b1;
               state_in           = S_IDLE;
               if (op_ff == ptt_pkg::OP_INSERT_ONCE ||
                   op_ff == ptt_pkg::OP_INSERT_REPEAT) begin
                  if (hit_ff) begin
                     rsp_status_in = ptt_pkg::ST_EXISTS;
                  end else if (!free_ff) begin
                     rsp_status_in = ptt_pkg::ST_FULL;
                  end else begin
                     cmd = ptt_pkg::CMD_INSERT;
                  end
               end else if (op_ff == ptt_pkg::OP_DELETE) begin
                  cmd = ptt_pkg::CMD_DELETE;
               end else if (op_ff == ptt_pkg::OP_RELOAD) begin
                  if (hit_ff) begin
                     cmd = ptt_pkg::CMD_RELOAD;
                  end else begin
                     rsp_status_in = ptt_pkg::ST_MISSING;
                  end
               end
            end
         end
         S_TICK: begin
            cmd      = ptt_pkg::CMD_TICK;
            cnt_in   = CNT_W'(DRAIN_CYCLES);
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (cnt_ff == '0) begin
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = ptt_pkg::ST_OK;
               rsp_fired_valid_in = held_w[0].vld;
               rsp_fired_id_in    = held_w[0].vld ? held_w[0].key : '0;
               rsp_last_in        = !held_w[1].vld;
               shift              = held_w[0].vld;
               if (!held_w[1].vld) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         cnt_ff       <= '0;
         step_ff      <= ptt_pkg::TICK_STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      id_ff              <= id_in;
      ms_ff              <= ms_in;
      hit_ff             <= hit_in;
      free_ff            <= free_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_fired_valid_ff <= rsp_fired_valid_in;
      rsp_fired_id_ff    <= rsp_fired_id_in;
      rsp_last_ff        <= rsp_last_in;
   end

endmodule

// File: verif/tb_periodic_timer_table.sv
// Testbench for periodic_timer_table: directed and random commands checked word by word.
module tb_periodic_timer_table;
   timeunit 1ns;
   timeprecision 1ps;

   import ptt_pkg::*;

   localparam int TABLE_SLOTS   = 16;
   localparam int PHASE_ITEMS   = 80;
   localparam int SETTLE_CYCLES = TABLE_SLOTS + 24;
   localparam int QUIET_LIMIT   = 2000;

   localparam logic [2:0] TICK_STEP_ADDR = 3'd0;

   localparam op_type OP_SPARE_LO  = op_type'(5);
   localparam op_type OP_SPARE_MID = op_type'(6);
   localparam op_type OP_SPARE_HI  = op_type'(7);

   class timer_table_check;
      typedef struct {
         status_type status;
         logic       fired_valid;
         id_type     fired_id;
         logic       last;
      } word_type;

      logic     slot_live   [TABLE_SLOTS];
      id_type   slot_key    [TABLE_SLOTS];
      logic     slot_repeat [TABLE_SLOTS];
      ms_type   slot_period [TABLE_SLOTS];
      ms_type   slot_left   [TABLE_SLOTS];
      step_type tick_step;
      word_type due_words[$];
      int       errors;

      function new();
         tick_step = TICK_STEP_RESET;
         errors    = 0;
         foreach (slot_live[i]) slot_live[i] = 1'b0;
      endfunction

      function int slot_of(id_type id);
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_live[i] && slot_key[i] == id) return i;
         return -1;
      endfunction

      function void add_due(status_type status, logic fv, id_type id, logic last);
         word_type w;
         w.status      = status;
         w.fired_valid = fv;
         w.fired_id    = id;
         w.last        = last;
         due_words.push_back(w);
      endfunction

      function void note_command(op_type op, id_type id, logic [15:0] secs);
         ms_type     ms;
         int         slot;
         status_type status;
         id_type     fired[$];
         ms     = secs * MS_PER_SECOND;
         status = ST_OK;
         case (op)
            OP_INSERT_ONCE, OP_INSERT_REPEAT: begin
               if (slot_of(id) >= 0) begin
                  status = ST_EXISTS;
               end else begin
                  slot = -1;
                  for (int i = 0; i < TABLE_SLOTS; i++)
                     if (!slot_live[i] && slot < 0) slot = i;
                  if (slot < 0) begin
                     status = ST_FULL;
                  end else begin
                     slot_live[slot]   = 1'b1;
                     slot_key[slot]    = id;
                     slot_repeat[slot] = (op == OP_INSERT_REPEAT);
                     slot_period[slot] = ms;
                     slot_left[slot]   = ms;
                  end
               end
            end
            OP_DELETE: begin
               slot = slot_of(id);
               if (slot >= 0) slot_live[slot] = 1'b0;
            end
            OP_RELOAD: begin
               slot = slot_of(id);
               if (slot >= 0) begin
                  slot_period[slot] = ms;
                  slot_left[slot]   = ms;
               end else begin
                  status = ST_MISSING;
               end
            end
            OP_TICK: begin
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  if (!slot_live[i]) continue;
                  if (slot_left[i] == 0) begin
                     fired.push_back(slot_key[i]);
                     if (slot_repeat[i]) slot_left[i] = slot_period[i];
                     else slot_live[i] = 1'b0;
                  end else if (slot_left[i] > tick_step) begin
                     slot_left[i] = slot_left[i] - tick_step;
                  end else begin
                     slot_left[i] = '0;
                  end
               end
               fired.sort();
               while (fired.size() > MAX_RESULTS) void'(fired.pop_back());
               if (fired.size() == 0) add_due(ST_OK, 1'b0, '0, 1'b1);
               foreach (fired[j]) add_due(ST_OK, 1'b1, fired[j], j == fired.size() - 1);
               return;
            end
            default: ;
         endcase
         add_due(status, 1'b0, '0, 1'b1);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_word(status_type status, logic fv, id_type id, logic last);
         word_type want;
         if (due_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: expected none, actual status %0d fired %0b id %0h last %0b",
                     $time, status, fv, id, last);
            return;
         end
         want = due_words.pop_front();
         compare_field("status", want.status, status);
         compare_field("fired_valid", want.fired_valid, fv);
         compare_field("fired_id", want.fired_id, id);
         compare_field("last", want.last, last);
      endfunction

      function void live_keys(ref id_type keys[$]);
         keys.delete();
         foreach (slot_live[i])
            if (slot_live[i]) keys.push_back(slot_key[i]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_opcode = '0;
   logic [15:0] req_timer_id = '0;
   logic [15:0] req_timeout_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_fired_valid;
   logic [15:0] rsp_fired_id;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   timer_table_check sb;
   bit send_gaps = 1'b0;
   bit rsp_gaps  = 1'b0;
   int cmds_sent = 0;
   int rsp_hold  = 0;
   int quiet_cycles = 0;

   periodic_timer_table #(.ENTRIES(TABLE_SLOTS)) u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random back-pressure per word when rsp_gaps is set
   always @(posedge clock) begin : rsp_side
      int wait_cycles;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         sb.check_word(rsp_status, rsp_fired_valid, rsp_fired_id, rsp_last);
         wait_cycles = rsp_gaps ? $urandom_range(0, 14) : 0;
         rsp_ready <= (wait_cycles == 0);
         rsp_hold  <= (wait_cycles > 0) ? wait_cycles - 1 : 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_cmd(op_type op, id_type id, logic [15:0] secs);
      int gap;
      gap = send_gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_timer_id        <= id;
      req_timeout_seconds <= secs;
      do @(posedge clock); while (!req_ready);
      sb.note_command(op, id, secs);
      if (op <= OP_TICK) cmds_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // optional write, then read back tick_step_ms
   task automatic csr_tick_step(bit do_write, step_type value);
      if (do_write) begin
         csr_psel   <= 1'b1;
         csr_pwrite <= 1'b1;
         csr_paddr  <= TICK_STEP_ADDR;
         csr_pwdata <= 32'(value);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         sb.tick_step = value;
      end
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= TICK_STEP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== 32'(sb.tick_step)) begin
         sb.errors++;
         $display("%0t: tick_step_ms readback mismatch: expected %0h, actual %0h",
                  $time, sb.tick_step, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return OP_INSERT_ONCE;
      if (r < 55) return OP_INSERT_REPEAT;
      if (r < 70) return OP_DELETE;
      if (r < 85) return OP_RELOAD;
      return OP_TICK;
   endfunction

   function automatic id_type pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r >= 90) return id_type'($urandom);
      r = $urandom_range(0, 19);
      if (r == 18) return 16'hFFFF;
      if (r == 19) return 16'h8000;
      return id_type'(r);
   endfunction

   function automatic logic [15:0] pick_secs();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return '0;
      if (r < 90) return 16'($urandom_range(1, 3));
      return 16'($urandom);
   endfunction

   task automatic clear_table();
      id_type keys[$];
      sb.live_keys(keys);
      foreach (keys[k]) send_cmd(OP_DELETE, keys[k], 16'($urandom));
   endtask

   task automatic run_directed();
      send_cmd(OP_TICK, 16'h0000, 16'h0000);
      send_cmd(OP_INSERT_ONCE, 16'h0000, 16'h0000);
      send_cmd(OP_INSERT_REPEAT, 16'hFFFF, 16'hFFFF);
      send_cmd(OP_INSERT_REPEAT, 16'h0000, 16'h0001);
      send_cmd(OP_RELOAD, 16'h1234, 16'h0002);
      send_cmd(OP_DELETE, 16'h4321, 16'h0000);
      send_cmd(OP_SPARE_LO, 16'hFFFF, 16'hFFFF);
      send_cmd(OP_SPARE_MID, 16'h0000, 16'h0000);
      send_cmd(OP_SPARE_HI, 16'hA5A5, 16'h5A5A);
      send_cmd(OP_TICK, 16'h0000, 16'h0000);
      // repeating timer with zero period fires every tick
      send_cmd(OP_RELOAD, 16'hFFFF, 16'h0000);
      send_cmd(OP_TICK, 16'h0000, 16'h0000);
      send_cmd(OP_TICK, 16'h0000, 16'h0000);
      send_cmd(OP_INSERT_ONCE, 16'h5555, 16'h0001);
      repeat (6) send_cmd(OP_TICK, 16'h0000, 16'h0000);
      send_cmd(OP_DELETE, 16'hFFFF, 16'h0000);
      send_cmd(OP_DELETE, 16'hFFFF, 16'h0000);
      send_cmd(OP_TICK, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic run_sequence();
      int     kind;
      id_type base;
      send_gaps = ($urandom_range(0, 3) != 0);
      rsp_gaps  = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
         repeat ($urandom_range(1, 6)) send_cmd(pick_op(), pick_id(), pick_secs());
         repeat ($urandom_range(1, 4)) send_cmd(OP_TICK, pick_id(), pick_secs());
      end else if (kind < 16) begin
         // fill past capacity, then a duplicate while full
         base = id_type'($urandom_range(0, 65535 - TABLE_SLOTS - 2));
         for (int i = 0; i <= TABLE_SLOTS; i++)
            send_cmd($urandom_range(0, 1) ? OP_INSERT_REPEAT : OP_INSERT_ONCE,
                     base + id_type'(i), pick_secs());
         send_cmd(OP_INSERT_ONCE, base, pick_secs());
         repeat (2) send_cmd(OP_TICK, pick_id(), pick_secs());
         if ($urandom_range(0, 1)) clear_table();
      end else if (kind < 19) begin
         repeat ($urandom_range(1, 4))
            send_cmd(op_type'($urandom_range(0, 7)), id_type'($urandom), 16'($urandom));
      end else begin
         clear_table();
      end
   endtask

   initial begin
      step_type step_plan[5];
      int       phase_end;
      step_plan = '{16'hFFFF, 16'h0001, 16'h0000, 16'd1000, 16'h0000};
      step_plan[4] = step_type'($urandom_range(2, 5000));
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_tick_step(1'b0, TICK_STEP_RESET);
      run_directed();
      drain();
      foreach (step_plan[p]) begin
         csr_tick_step(1'b1, step_plan[p]);
         phase_end = cmds_sent + PHASE_ITEMS;
         while (cmds_sent < phase_end) run_sequence();
         clear_table();
         drain();
      end
      if (sb.errors == 0 && sb.due_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_timer_cell.sv
hw/rtl/ptt_sort_cell.sv
hw/rtl/periodic_timer_table.sv
verif/tb_periodic_timer_table.sv
